FILE: src/system_health_monitor_assert.svh
`ifndef SYSTEM_HEALTH_MONITOR_ASSERT_SVH
`define SYSTEM_HEALTH_MONITOR_ASSERT_SVH
// Assertion macros shared by the checker.
`define SHM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SHM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

FILE: src/shm_pkg.sv
package shm_pkg;
    localparam int TimeWidth = 32;
    localparam int CountWidth = 16;
    localparam int RateWidth = 16;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 32;
    localparam int QueueDepth = 2;

    localparam logic [CfgIdxWidth-1:0] CfgWindow = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CfgStatus = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CfgCooldown = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CfgTimeout = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CfgMinFps = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CfgMinHeap = 3'd5;
    localparam logic [CfgIdxWidth-1:0] CfgMaxRate = 3'd6;
    localparam logic [CfgIdxWidth-1:0] CfgDisplay = 3'd7;

    localparam logic [1:0] EvOther = 2'd0;
    localparam logic [1:0] EvHeartbeat = 2'd1;
    localparam logic [1:0] EvFrame = 2'd2;
    localparam logic [1:0] EvOwn = 2'd3;

    localparam logic [2:0] AnNone = 3'd0;
    localparam logic [2:0] AnHeartbeat = 3'd1;
    localparam logic [2:0] AnMemory = 3'd2;
    localparam logic [2:0] AnFps = 3'd3;
    localparam logic [2:0] AnLoad = 3'd4;

    localparam logic KindStatus = 1'b0;
    localparam logic KindAnomaly = 1'b1;

    typedef struct packed {
        logic        command;
        logic [1:0]  event_kind;
        logic [31:0] stamp;
        logic [23:0] free_heap;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic        last_of_run;
        logic [31:0] report_time;
        logic [6:0]  health_score;
        logic [2:0]  anomaly_code;
        logic        degraded;
        logic        heartbeat_ok;
        logic        render_ok;
        logic        memory_ok;
        logic        load_ok;
        logic [15:0] event_rate;
        logic [15:0] frame_rate;
    } t_out_word;

    typedef struct packed {
        logic [31:0] window_ms;
        logic [31:0] status_interval_ms;
        logic [31:0] anomaly_cooldown_ms;
        logic [31:0] stale_limit_ms;
        logic [15:0] fps_floor;
        logic [23:0] min_free_heap;
        logic [15:0] max_event_rate;
        logic        display_on;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WIN, ST_DIV, ST_EVAL, ST_STATUS, ST_ANOM
    } t_state;
endpackage

FILE: src/system_health_monitor.sv
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_stall  | t_in_word
// output  | out       | o_valid / i_stall  | t_out_word
// config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
// An event word passes through the queue to the back end.
// A tick runs the bit-serial divider when the window closes and skips it
// otherwise; output stalls can hold it.
// Reset is synchronous and restores the default configuration; it clears the counters, rates, timestamps and o_valid.
// The two-entry queue keeps accepting while the back end waits on the output, until it is full.
module system_health_monitor #(
    parameter int TIME_WIDTH = shm_pkg::TimeWidth,
    parameter int COUNT_WIDTH = shm_pkg::CountWidth
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  shm_pkg::t_in_word                   i_word,
    output logic                                o_valid,
    input  logic                                i_stall,
    output shm_pkg::t_out_word                  o_word,
    input  logic                                i_cfg_we,
    input  logic [shm_pkg::CfgIdxWidth-1:0]     i_cfg_idx,
    input  logic [shm_pkg::CfgDataWidth-1:0]    i_cfg_data
);
    shm_pkg::t_cfg r_cfg;
    shm_pkg::t_in_word q_word;
    logic q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms <= 32'd1000;
            r_cfg.status_interval_ms <= 32'd1000;
            r_cfg.anomaly_cooldown_ms <= 32'd5000;
            r_cfg.stale_limit_ms <= 32'd3000;
            r_cfg.fps_floor <= 16'd10;
            r_cfg.min_free_heap <= 24'd20000;
            r_cfg.max_event_rate <= 16'd200;
            r_cfg.display_on <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                shm_pkg::CfgWindow: r_cfg.window_ms <= i_cfg_data;
                shm_pkg::CfgStatus: r_cfg.status_interval_ms <= i_cfg_data;
                shm_pkg::CfgCooldown: r_cfg.anomaly_cooldown_ms <= i_cfg_data;
                shm_pkg::CfgTimeout: r_cfg.stale_limit_ms <= i_cfg_data;
                shm_pkg::CfgMinFps: r_cfg.fps_floor <= i_cfg_data[15:0];
                shm_pkg::CfgMinHeap: r_cfg.min_free_heap <= i_cfg_data[23:0];
                shm_pkg::CfgMaxRate: r_cfg.max_event_rate <= i_cfg_data[15:0];
                shm_pkg::CfgDisplay: r_cfg.display_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    shm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_word(q_word)
    );

    shm_back #(.TIME_WIDTH(TIME_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_word(q_word), .o_valid, .i_stall, .o_word
    );
endmodule

FILE: src/shm_front.sv
module shm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  shm_pkg::t_in_word i_word,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output shm_pkg::t_in_word o_q_word
);
    shm_pkg::t_in_word r_mem [shm_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == 2'(shm_pkg::QueueDepth));
    assign push = i_valid && !o_stall && !(i_word.command == 1'b0 &&
                  i_word.event_kind == shm_pkg::EvOwn);
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop = i_q_pop && o_q_valid;
    assign o_q_word = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_word;
    end
endmodule

FILE: src/shm_divider.sv
module shm_divider #(
    parameter int TIME_WIDTH = shm_pkg::TimeWidth,
    parameter int COUNT_WIDTH = shm_pkg::CountWidth
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COUNT_WIDTH-1:0] i_count_a,
    input  logic [COUNT_WIDTH-1:0] i_count_b,
    input  logic [TIME_WIDTH-1:0]  i_divisor,
    output logic                   o_done,
    output logic [15:0]            o_rate_a,
    output logic [15:0]            o_rate_b
);
    localparam int NW = COUNT_WIDTH + 10;
    localparam int RW = (TIME_WIDTH > NW ? TIME_WIDTH : NW) + 1;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_qa, r_qb;
    logic [RW-1:0] r_ra, r_rb;
    logic [TIME_WIDTH-1:0] r_d;
    logic [CW-1:0] r_n;
    logic r_busy;
    logic [RW-1:0] sa, sb, dx;

    assign dx = RW'(r_d);
    assign sa = {r_ra[RW-2:0], r_qa[NW-1]};
    assign sb = {r_rb[RW-2:0], r_qb[NW-1]};
    assign o_done = r_busy && (r_n == CW'(0));
    assign o_rate_a = (r_qa > NW'(16'hFFFF)) ? 16'hFFFF : r_qa[15:0];
    assign o_rate_b = (r_qb > NW'(16'hFFFF)) ? 16'hFFFF : r_qb[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_n <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_n <= CW'(NW);
        end else if (r_busy) begin
            if (r_n == CW'(0)) r_busy <= 1'b0;
            else r_n <= r_n - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qa <= NW'(i_count_a) * NW'(1000);
            r_qb <= NW'(i_count_b) * NW'(1000);
            r_ra <= '0;
            r_rb <= '0;
            r_d <= i_divisor;
        end else if (r_busy && r_n != CW'(0)) begin
            if (sa >= dx) begin
                r_ra <= sa - dx;
                r_qa <= {r_qa[NW-2:0], 1'b1};
            end else begin
                r_ra <= sa;
                r_qa <= {r_qa[NW-2:0], 1'b0};
            end
            if (sb >= dx) begin
                r_rb <= sb - dx;
                r_qb <= {r_qb[NW-2:0], 1'b1};
            end else begin
                r_rb <= sb;
                r_qb <= {r_qb[NW-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: src/shm_back.sv
module shm_back #(
    parameter int TIME_WIDTH = shm_pkg::TimeWidth,
    parameter int COUNT_WIDTH = shm_pkg::CountWidth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shm_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  shm_pkg::t_in_word  i_q_word,
    output logic               o_valid,
    input  logic               i_stall,
    output shm_pkg::t_out_word o_word
);
    shm_pkg::t_state r_state, n_state;
    logic [TIME_WIDTH-1:0] r_hb, r_act, r_win, r_stat, r_anom, r_now, r_el;
    logic [COUNT_WIDTH-1:0] r_ec, r_fc;
    logic [15:0] r_re, r_rf;
    logic [2:0] r_prev;
    logic [23:0] r_heap;
    logic r_hb_ok, r_rn, r_mem, r_ld, r_do_st, r_do_an;
    logic [6:0] r_score;
    logic [2:0] r_code;
    logic r_ovalid;
    shm_pkg::t_out_word r_out;
    logic div_start, div_done;
    logic [15:0] div_a, div_b;
    logic [TIME_WIDTH-1:0] now, el, hb_age, act_age;
    logic hb, rn, mem, ld;
    logic [6:0] score;
    logic [2:0] code;
    logic out_free;

    assign now = TIME_WIDTH'(i_q_word.stamp);
    assign el = now - r_win;
    assign hb_age = r_now - r_hb;
    assign act_age = r_now - r_act;
    assign out_free = !r_ovalid || !i_stall;
    assign o_valid = r_ovalid;
    assign o_word = r_out;

    shm_divider #(.TIME_WIDTH(TIME_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_count_a(r_ec), .i_count_b(r_fc),
        .i_divisor(r_el), .o_done(div_done), .o_rate_a(div_a), .o_rate_b(div_b)
    );

    always_comb begin
        hb = (hb_age <= TIME_WIDTH'(i_cfg.stale_limit_ms)) ||
             (act_age <= TIME_WIDTH'(i_cfg.stale_limit_ms));
        rn = !i_cfg.display_on || (r_rf >= i_cfg.fps_floor);
        mem = r_heap >= i_cfg.min_free_heap;
        ld = r_re <= i_cfg.max_event_rate;
        score = 7'd100 - (hb ? 7'd0 : 7'd35) - (rn ? 7'd0 : 7'd25)
              - (mem ? 7'd0 : 7'd25) - (ld ? 7'd0 : 7'd15);
        if (!hb) code = shm_pkg::AnHeartbeat;
        else if (!mem) code = shm_pkg::AnMemory;
        else if (!rn) code = shm_pkg::AnFps;
        else if (!ld) code = shm_pkg::AnLoad;
        else code = shm_pkg::AnNone;
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        div_start = 1'b0;
        case (r_state)
            shm_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_word.command) n_state = shm_pkg::ST_WIN;
                end
            end
            shm_pkg::ST_WIN: begin
                if (r_el >= TIME_WIDTH'(i_cfg.window_ms) && r_el != '0) begin
                    div_start = 1'b1;
                    n_state = shm_pkg::ST_DIV;
                end else begin
                    n_state = shm_pkg::ST_EVAL;
                end
            end
            shm_pkg::ST_DIV: if (div_done) n_state = shm_pkg::ST_EVAL;
            shm_pkg::ST_EVAL: n_state = shm_pkg::ST_STATUS;
            shm_pkg::ST_STATUS: begin
                if (!r_do_st) n_state = shm_pkg::ST_ANOM;
                else if (out_free) n_state = shm_pkg::ST_ANOM;
            end
            shm_pkg::ST_ANOM: begin
                if (!r_do_an || out_free) n_state = shm_pkg::ST_IDLE;
            end
            default: n_state = shm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shm_pkg::ST_IDLE;
            r_hb <= '0; r_act <= '0; r_win <= '0; r_stat <= '0; r_anom <= '0;
            r_ec <= '0; r_fc <= '0; r_re <= '0; r_rf <= '0;
            r_prev <= shm_pkg::AnNone;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                shm_pkg::ST_IDLE: begin
                    if (i_q_valid && !i_q_word.command) begin
                        if (r_ec != '1) r_ec <= r_ec + COUNT_WIDTH'(1);
                        r_act <= now;
                        if (i_q_word.event_kind == shm_pkg::EvHeartbeat) r_hb <= now;
                        if (i_q_word.event_kind == shm_pkg::EvFrame && r_fc != '1)
                            r_fc <= r_fc + COUNT_WIDTH'(1);
                    end
                end
                shm_pkg::ST_DIV: begin
                    if (div_done) begin
                        r_re <= div_a;
                        r_rf <= div_b;
                        r_ec <= '0;
                        r_fc <= '0;
                        r_win <= r_now;
                    end
                end
                shm_pkg::ST_STATUS: begin
                    if (r_do_st && out_free) begin
                        r_ovalid <= 1'b1;
                        r_stat <= r_now;
                    end
                end
                shm_pkg::ST_ANOM: begin
                    if (r_do_an && out_free) begin
                        r_ovalid <= 1'b1;
                        r_anom <= r_now;
                    end
                    if (!r_do_an || out_free) r_prev <= r_code;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == shm_pkg::ST_IDLE && i_q_valid) begin
            r_now <= now;
            r_el <= el;
            r_heap <= i_q_word.free_heap;
        end
        if (r_state == shm_pkg::ST_EVAL) begin
            r_hb_ok <= hb; r_rn <= rn; r_mem <= mem; r_ld <= ld;
            r_score <= score; r_code <= code;
            r_do_st <= (r_now - r_stat) >= TIME_WIDTH'(i_cfg.status_interval_ms);
            r_do_an <= code != r_prev && code != shm_pkg::AnNone &&
                       (r_now - r_anom) >= TIME_WIDTH'(i_cfg.anomaly_cooldown_ms);
        end
        if ((r_state == shm_pkg::ST_STATUS && r_do_st && out_free) ||
            (r_state == shm_pkg::ST_ANOM && r_do_an && out_free)) begin
            r_out.result_kind <= (r_state == shm_pkg::ST_ANOM) ?
                                 shm_pkg::KindAnomaly : shm_pkg::KindStatus;
            r_out.last_of_run <= (r_state == shm_pkg::ST_ANOM) || !r_do_an;
            r_out.report_time <= 32'(r_now);
            r_out.health_score <= r_score;
            r_out.anomaly_code <= r_code;
            r_out.degraded <= r_score < 7'd100;
            r_out.heartbeat_ok <= r_hb_ok;
            r_out.render_ok <= r_rn;
            r_out.memory_ok <= r_mem;
            r_out.load_ok <= r_ld;
            r_out.event_rate <= r_re;
            r_out.frame_rate <= r_rf;
        end
    end
endmodule

FILE: src/shm_checker.sv
`include "system_health_monitor_assert.svh"
module shm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input shm_pkg::t_out_word o_word
);
    `SHM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_word))
    `SHM_ASSERT_IMP(a_degraded, i_clk, i_rst_n, o_valid, o_word.degraded == (o_word.health_score < 7'd100))
    `SHM_ASSERT_IMP(a_anom_code, i_clk, i_rst_n, o_valid && o_word.result_kind, o_word.anomaly_code != shm_pkg::AnNone)
    `SHM_ASSERT_IMP(a_anom_last, i_clk, i_rst_n, o_valid && o_word.result_kind, o_word.last_of_run)
endmodule

bind system_health_monitor shm_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_word
);
